### hw/rtl/sigmoid_xent_row_mean_macros.svh
// Assertion macros for the row-mean loss block.
`ifndef SIGMOID_XENT_ROW_MEAN_MACROS_SVH
`define SIGMOID_XENT_ROW_MEAN_MACROS_SVH
`ifndef SYNTHESIS
`define SXRM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SXRM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SXRM_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define SXRM_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### hw/rtl/sxrm_pkg.sv
package sxrm_pkg;
   localparam int LOGIT_W = 16;
   localparam int TARGET_W = 16;
   localparam int OUT_W = 25;
   localparam int SUM_W = 37;
   localparam int TERM_W = 42;
   localparam int SP_W = 17;
   localparam int ROM_W = 18;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 13;
   localparam logic [CSR_IDX_W-1:0] CSR_LOSS_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_LENGTH = 1'd1;
   localparam logic [1:0] MODE_PLAIN = 2'd0;
   localparam logic [1:0] MODE_LOGD = 2'd1;
   localparam logic [1:0] MODE_UNJOINED = 2'd2;
   localparam logic [24:0] OUT_LIMIT = 25'd8454144;
   localparam logic [63:0] STEP_K = 64'd4034748382;

   typedef enum logic [3:0] {
      ST_ACCUM  = 4'b0001,
      ST_DIVIDE = 4'b0010,
      ST_FINISH = 4'b0100,
      ST_OUTPUT = 4'b1000
   } state_type;

   typedef struct packed {
      logic load;        // accept element into pipeline
      logic div_start;   // start row divide
      logic clear_row;   // zero sum after divide starts
   } cmd_type;

   typedef struct packed {
      logic row_done;    // element entering pipeline closes the row
      logic pipe_busy;   // terms still in flight
      logic div_done;
   } status_type;

   // Returns exp(-idx/16) in Q32.32, evaluated at elaboration only.
   function automatic logic [63:0] sp_exp(input int idx);
      logic [63:0] e;
      logic [127:0] m;
      e = 64'd1 << 32;
      for (int i = 0; i < idx; i++) begin
         m = 128'(e) * 128'(STEP_K) + (128'd1 << 31);
         e = m[95:32];
      end
      return e;
   endfunction
endpackage

### hw/rtl/sxrm_ctrl.sv
module sxrm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  sxrm_pkg::status_type   status,
   output sxrm_pkg::cmd_type      cmd
);
   import sxrm_pkg::*;

   state_type state_ff, state_in;
   logic out_ff, out_in;

   always_comb begin
      state_in = state_ff;
      out_in = out_ff;
      cmd = '0;
      req_tready = 1'b0;
      if (out_ff && rsp_tready) begin
         out_in = 1'b0;
      end
      case (state_ff)
         ST_ACCUM: begin
            req_tready = !reset;
            cmd.load = req_tvalid && !reset;
            if (cmd.load && status.row_done) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (!status.pipe_busy && !out_ff) begin
               cmd.div_start = 1'b1;
               cmd.clear_row = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.div_done) begin
               out_in = 1'b1;
               state_in = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   assign rsp_tvalid = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
         out_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_ff <= out_in;
      end
   end
endmodule

### hw/rtl/sxrm_datapath.sv
module sxrm_datapath #(
   parameter int MAX_ROW = 4096,
   parameter int TABLE_DEPTH = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [sxrm_pkg::LOGIT_W-1:0]  logit,
   input  logic [sxrm_pkg::TARGET_W-1:0] target,
   input  logic [1:0]                    loss_mode,
   input  logic [12:0]                   row_length,
   input  sxrm_pkg::cmd_type             cmd,
   output sxrm_pkg::status_type          status,
   output logic [sxrm_pkg::OUT_W-1:0]    mean_loss
);
   import sxrm_pkg::*;

   localparam int CNT_W = $clog2(MAX_ROW + 1);
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int DIV_STEPS = SUM_W + 2;
   localparam int STEP_W = $clog2(DIV_STEPS + 1);
   localparam int LEN_W = (CNT_W > 13) ? CNT_W : 13;

   // Softplus table, filled at elaboration with an atanh series.
   logic [SP_W-1:0] rom [TABLE_DEPTH];
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_rom
      localparam logic [63:0] E = sp_exp(g);
      localparam logic [63:0] Z = (E << 30) / ((64'd2 << 32) + E);
      localparam logic [63:0] Z2 = (Z * Z) >> 30;
      localparam logic [63:0] P3 = (Z * Z2) >> 30;
      localparam logic [63:0] P5 = (P3 * Z2) >> 30;
      localparam logic [63:0] P7 = (P5 * Z2) >> 30;
      localparam logic [63:0] P9 = (P7 * Z2) >> 30;
      localparam logic [63:0] P11 = (P9 * Z2) >> 30;
      localparam logic [63:0] P13 = (P11 * Z2) >> 30;
      localparam logic [63:0] P15 = (P13 * Z2) >> 30;
      localparam logic [63:0] P17 = (P15 * Z2) >> 30;
      localparam logic [63:0] P19 = (P17 * Z2) >> 30;
      localparam logic [63:0] P21 = (P19 * Z2) >> 30;
      localparam logic [63:0] P23 = (P21 * Z2) >> 30;
      localparam logic [63:0] P25 = (P23 * Z2) >> 30;
      localparam logic [63:0] ACC = Z + P3 / 64'd3 + P5 / 64'd5 + P7 / 64'd7
         + P9 / 64'd9 + P11 / 64'd11 + P13 / 64'd13 + P15 / 64'd15 + P17 / 64'd17
         + P19 / 64'd19 + P21 / 64'd21 + P23 / 64'd23 + P25 / 64'd25;
      localparam logic [63:0] ENTRY = ((ACC << 1) + (64'd1 << 13)) >> 14;
      assign rom[g] = ENTRY[SP_W-1:0];
   end

   // Stage 0: fetch table entry, clamp target.
   logic signed [16:0] x_s;
   logic [16:0] ax;
   logic [16:0] idx_full;
   logic [15:0] t_cl;
   logic [SP_W-1:0] sp_s0;
   assign x_s = {logit[15], logit};
   assign ax = x_s[16] ? 17'(-x_s) : 17'(x_s);
   assign idx_full = (ax + 17'd8) >> 4;
   assign t_cl = (target > 16'd32768) ? 16'd32768 : target;
   assign sp_s0 = (idx_full < 17'(TABLE_DEPTH)) ? rom[idx_full[IDX_W-1:0]] : '0;

   logic v1_ff;
   logic signed [16:0] x1_ff;
   logic [16:0] t1_ff;
   logic [SP_W-1:0] sp1_ff;
   logic [1:0] mode1_ff;

   // Stage 1: two products per mode, one in MODE_LOGD.
   logic signed [TERM_W-1:0] pa, pb;
   logic signed [TERM_W-1:0] xs8, spv, tt, tc;
   logic pos1;
   always_comb begin
      pos1 = !x1_ff[16];
      xs8 = TERM_W'(x1_ff) <<< 8;
      spv = TERM_W'($signed({1'b0, sp1_ff}));
      tt  = TERM_W'($signed({1'b0, t1_ff}));
      tc  = TERM_W'(32768) - tt;
      case (mode1_ff)
         MODE_LOGD: begin
            pa = (pos1 ? TERM_W'(0) : xs8) - spv;
            pb = (tt <<< 1) - TERM_W'(32768);
         end
         MODE_UNJOINED: begin
            pa = (pos1 ? xs8 : TERM_W'(0)) + spv;
            pb = tc;
         end
         default: begin
            pa = xs8;
            pb = tt - (pos1 ? TERM_W'(32768) : TERM_W'(0));
         end
      endcase
   end

   logic v2_ff;
   logic [1:0] mode2_ff;
   logic signed [TERM_W-1:0] m1_ff, m2_ff;
   logic signed [TERM_W-1:0] p1_in, p2_in;
   always_comb begin
      p1_in = TERM_W'($signed(pa[25:0]) * $signed(pb[18:0]));
      case (mode1_ff)
         MODE_UNJOINED: p2_in = TERM_W'($signed(xs8[25:0]) * $signed(tt[18:0]));
         MODE_LOGD: p2_in = '0;
         default: p2_in = TERM_W'($signed(spv[18:0]) * $signed(19'sd32768));
      endcase
   end

   // Stage 2: combine and round to Q.16.
   logic signed [TERM_W-1:0] term31;
   logic signed [TERM_W-1:0] rnd;
   always_comb begin
      case (mode2_ff)
         MODE_UNJOINED: term31 = m2_ff - m1_ff;
         MODE_LOGD: term31 = m1_ff;
         default: term31 = m1_ff - m2_ff;
      endcase
      rnd = (term31 + TERM_W'(16384)) >>> 15;
   end

   logic signed [SUM_W-1:0] sum_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [LEN_W-1:0] len_eff;
   always_comb begin
      if (row_length == 13'd0) len_eff = LEN_W'(1);
      else if (LEN_W'(row_length) > LEN_W'(MAX_ROW)) len_eff = LEN_W'(MAX_ROW);
      else len_eff = LEN_W'(row_length);
   end

   assign status.row_done = (LEN_W'(cnt_ff) + LEN_W'(1)) >= len_eff;
   assign status.pipe_busy = v1_ff | v2_ff;

   // Restoring divider: (2|sum| + L) / (2L), one bit per cycle.
   logic [SUM_W+1:0] num_ff, rem_ff;
   logic [LEN_W+1:0] den_ff;
   logic [STEP_W-1:0] step_ff;
   logic busy_ff, done_ff, neg_ff;
   logic [SUM_W+1:0] rem_sh;
   logic [SUM_W-1:0] mag;
   assign mag = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign rem_sh = {rem_ff[SUM_W:0], num_ff[SUM_W+1]};
   assign status.div_done = done_ff;

   logic [SUM_W+1:0] q_full;
   logic [OUT_W-1:0] qsat;
   assign q_full = num_ff;
   assign qsat = (q_full > (SUM_W+2)'(OUT_LIMIT)) ? OUT_LIMIT : q_full[OUT_W-1:0];

   always_ff @(posedge clock) begin
      x1_ff <= x_s;
      t1_ff <= {1'b0, t_cl};
      sp1_ff <= sp_s0;
      mode1_ff <= loss_mode;
      mode2_ff <= mode1_ff;
      m1_ff <= p1_in;
      m2_ff <= p2_in;
      if (cmd.div_start) begin
         num_ff <= (SUM_W+2)'({mag, 1'b0}) + (SUM_W+2)'(len_eff);
         den_ff <= (LEN_W+2)'({len_eff, 1'b0});
         rem_ff <= '0;
         neg_ff <= sum_ff[SUM_W-1];
      end else if (busy_ff) begin
         if (rem_sh >= (SUM_W+2)'(den_ff)) begin
            rem_ff <= rem_sh - (SUM_W+2)'(den_ff);
            num_ff <= {num_ff[SUM_W:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            num_ff <= {num_ff[SUM_W:0], 1'b0};
         end
      end
      if (done_ff) begin
         mean_loss <= neg_ff ? qsat : OUT_W'(-qsat);
      end
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         sum_ff <= '0;
         cnt_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         v1_ff <= cmd.load;
         v2_ff <= v1_ff;
         if (cmd.clear_row) begin
            sum_ff <= '0;
         end else if (v2_ff) begin
            sum_ff <= sum_ff + SUM_W'(rnd);
         end
         if (cmd.load) begin
            cnt_ff <= status.row_done ? '0 : cnt_ff + CNT_W'(1);
         end
         done_ff <= 1'b0;
         if (cmd.div_start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
endmodule

### hw/rtl/sigmoid_xent_row_mean.sv
// Row-averaged sigmoid cross-entropy. Each req beat carries one (logit, target) pair;
// elements of a row are taken one per cycle through a three-stage term pipeline.
// When a row closes, the block stops taking beats while a bit-serial divider forms the
// rounded mean, then offers one rsp beat with the negated, saturated mean. Configuration
// is to be written by the user only while idle; the block itself does not enforce this.
`include "sigmoid_xent_row_mean_macros.svh"
module sigmoid_xent_row_mean #(
   parameter int MAX_ROW = 4096,
   parameter int TABLE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] logit, [31:16] target
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [24:0] mean_loss
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [sxrm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sxrm_pkg::CSR_DATA_W-1:0] csr_data
);
   import sxrm_pkg::*;

   cmd_type cmd;
   status_type status;
   logic [1:0] mode_ff;
   logic [12:0] len_ff;
   logic [OUT_W-1:0] mean_loss;

   assign csr_ready = !reset;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PLAIN;
         len_ff <= 13'd1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LOSS_MODE: mode_ff <= csr_data[1:0];
            CSR_ROW_LENGTH: len_ff <= csr_data;
            default: ;
         endcase
      end
   end

   sxrm_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .status(status), .cmd(cmd)
   );

   sxrm_datapath #(.MAX_ROW(MAX_ROW), .TABLE_DEPTH(TABLE_DEPTH)) u_dp (
      .clock(clock), .reset(reset),
      .logit(req_tdata[15:0]), .target(req_tdata[31:16]),
      .loss_mode(mode_ff), .row_length(len_ff),
      .cmd(cmd), .status(status), .mean_loss(mean_loss)
   );

   assign rsp_tdata = {7'd0, mean_loss};

   `SXRM_ASSERT_IMP(a_no_accept_while_div, clock, reset, cmd.div_start, !req_tready, "accept during divide")
   `SXRM_ASSERT_NXT(a_rsp_holds, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result dropped")
   `SXRM_ASSERT_IMP(a_div_idle_pipe, clock, reset, cmd.div_start, !status.pipe_busy, "divide with terms in flight")
endmodule

### tb/sv/tb_sigmoid_xent_row_mean.sv
module tb_sigmoid_xent_row_mean;
   import sxrm_pkg::*;

   localparam logic [1:0] MODE_SPARE = 2'd3;   // unused code, acts as plain mode
   localparam int SP_DEPTH = 256;
   localparam int ROW_CAP = 4096;
   localparam longint SAT_LIMIT = 8454144;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   sigmoid_xent_row_mean DUT (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   logic [31:0]        pending_pairs[$];
   logic [OUT_W-1:0]   expected_means[$];
   longint             softplus_rom[SP_DEPTH];
   logic [1:0]         cur_mode = MODE_PLAIN;
   logic [12:0]        cur_row_len = 13'd1;
   longint             acc_sum = 0;
   int                 acc_count = 0;
   int                 send_idle_pct = 0;
   int                 recv_idle_pct = 0;
   int                 errors = 0;
   bit                 hold_request = 1'b0;
   bit                 hold_taken = 1'b0;
   int                 hold_left = 0;

   // log(1+exp(-i/16)) in Q8.16 via an integer atanh series.
   function automatic longint softplus_entry(input int idx);
      logic [127:0] prod;
      logic [63:0]  e, z, z2, p, acc;
      e = 64'd1 << 32;
      for (int i = 0; i < idx; i++) begin
         prod = 128'(e) * 128'd4034748382 + (128'd1 << 31);
         e = prod[95:32];
      end
      z = (e << 30) / ((64'd2 << 32) + e);
      z2 = (z * z) >> 30;
      p = z;
      acc = 0;
      for (int k = 1; k <= 25; k += 2) begin
         acc = acc + p / 64'(k);
         p = (p * z2) >> 30;
      end
      return longint'((2 * acc + (64'd1 << 13)) >> 14);
   endfunction

   task automatic predict_row_mean(input logic [31:0] pair);
      longint x, t, sp, term, d, spf, mag, q, len;
      bit pos;
      x = longint'($signed(pair[15:0]));
      t = longint'(pair[31:16]);
      if (t > 32768) t = 32768;
      pos = x >= 0;
      sp = (((pos ? x : -x) + 8) >> 4) < SP_DEPTH ? softplus_rom[((pos ? x : -x) + 8) >> 4] : 0;
      if (cur_mode == MODE_LOGD) begin
         d = (pos ? 0 : x * 256) - sp;
         term = d * (2 * t - 32768);
      end else if (cur_mode == MODE_UNJOINED) begin
         spf = (pos ? x * 256 : 0) + sp;
         term = x * t * 256 - (32768 - t) * spf;
      end else begin
         term = x * (t - (pos ? 32768 : 0)) * 256 - sp * 32768;
      end
      acc_sum += (term + 16384) >>> 15;
      acc_count++;
      len = cur_row_len;
      if (len == 0) len = 1;
      if (len > ROW_CAP) len = ROW_CAP;
      if (acc_count >= len) begin
         mag = acc_sum < 0 ? -acc_sum : acc_sum;
         q = (2 * mag + len) / (2 * len);
         if (q > SAT_LIMIT) q = SAT_LIMIT;
         expected_means.push_back(OUT_W'(acc_sum < 0 ? q : -q));
         acc_sum = 0;
         acc_count = 0;
      end
   endtask

   // Sender: holds a beat until accepted, then may idle at random.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_pairs.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left <= 400;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= hold_left == 0 && $urandom_range(99) >= recv_idle_pct;
   end

   // Monitor: predicts on each accepted req beat, checks each rsp beat.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            predict_row_mean(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_means.size() == 0) begin
               $error("unexpected rsp beat, mean_loss %0d", $signed(rsp_tdata[OUT_W-1:0]));
               errors++;
            end else begin
               if (rsp_tdata[OUT_W-1:0] !== expected_means[0]) begin
                  $error("mean_loss expected %0d actual %0d", $signed(expected_means[0]),
                         $signed(rsp_tdata[OUT_W-1:0]));
                  errors++;
               end
               void'(expected_means.pop_front());
            end
         end
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [12:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_LOSS_MODE) cur_mode = value[1:0];
      else cur_row_len = value;
   endtask

   task automatic drain_and_settle();
      while (pending_pairs.size() > 0 || expected_means.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic logic [31:0] random_pair();
      logic [15:0] x, t;
      case ($urandom_range(3))
         0: x = 16'($urandom);
         1: x = 16'($signed($urandom_range(600)) - 300);
         2: x = 16'(($urandom_range(1) ? 4088 : -4088) + $signed($urandom_range(40)) - 20);
         default: x = $urandom_range(1) ? 16'h7fff : 16'h8000;
      endcase
      case ($urandom_range(3))
         0, 1: t = 16'($urandom_range(32768));
         2: t = 16'($urandom);
         default: t = $urandom_range(1) ? 16'd32768 : 16'd0;
      endcase
      return {t, x};
   endfunction

   initial begin
      logic [1:0]  modes[9] = '{MODE_PLAIN, MODE_LOGD, MODE_UNJOINED, MODE_SPARE, MODE_LOGD,
                               MODE_UNJOINED, MODE_PLAIN, MODE_LOGD, MODE_UNJOINED};
      logic [12:0] lens[9] = '{13'd0, 13'd3, 13'd7, 13'd1, 13'd9, 13'd2, 13'd5, 13'd1, 13'd4};
      int          counts[9] = '{80, 90, 98, 60, 198, 80, 80, 60, 80};
      logic [15:0] edge_logits[8] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001,
                                      16'd4088, 16'd4087, -16'sd4088};
      logic [15:0] edge_targets[4] = '{16'd0, 16'd32768, 16'd32769, 16'hffff};

      for (int i = 0; i < SP_DEPTH; i++) softplus_rom[i] = softplus_entry(i);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: boundary logits and targets in every loss mode, one element per row.
      send_idle_pct = 15;
      recv_idle_pct = 49;
      foreach (modes[m]) if (m < 4) begin
         write_csr(CSR_LOSS_MODE, 13'(modes[m]));
         write_csr(CSR_ROW_LENGTH, 13'd1);
         for (int i = 0; i < 6; i++)
            pending_pairs.push_back({edge_targets[i % 4], edge_logits[(i + m * 2) % 8]});
         drain_and_settle();
      end

      foreach (modes[p]) begin
         if (p == 3) begin
            send_idle_pct = 49;
            recv_idle_pct = 15;
         end else if (p == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_csr(CSR_LOSS_MODE, 13'(modes[p]));
         write_csr(CSR_ROW_LENGTH, lens[p]);
         if (lens[p] == 13'd1 && !hold_request) hold_request = 1'b1;
         for (int i = 0; i < counts[p]; i++) pending_pairs.push_back(random_pair());
         drain_and_settle();
      end

      if (errors == 0)
         $display("tb_sigmoid_xent_row_mean: PASS");
      else
         $display("tb_sigmoid_xent_row_mean: FAIL");
      $finish;
   end

   initial begin
      #(8 * 2000000);
      $display("tb_sigmoid_xent_row_mean: FAIL");
      $finish;
   end
endmodule
